// File: design/dd_odo_pkg.sv
// shared types, widths and constants of the differential drive odometry block
// no dependencies; the cordic, the top level and the checker refer to it by scoped names
`default_nettype none

package dd_odo_pkg;

    // field widths
    localparam int VEL_W      = 16;
    localparam int RATE_W     = 16;
    localparam int DT_W       = 16;
    localparam int POS_W      = 32;
    localparam int ANG_W      = 32;
    localparam int Q15_W      = 16;
    localparam int VDT_W      = VEL_W + DT_W;
    localparam int PROD_W     = VDT_W + Q15_W;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INITIAL_X       = 2'd0,
        REG_INITIAL_Y       = 2'd1,
        REG_INITIAL_HEADING = 2'd2
    } t_reg_index;

    // cordic
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TBL_LEN          = 24;
    localparam int TBL_IDX_W        = 5;
    localparam int CORDIC_W         = 34;
    localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;

    // input transaction
    typedef struct packed {
        logic                     load_initial;
        logic signed [VEL_W-1:0]  linear_velocity;
        logic signed [RATE_W-1:0] angular_rate;
        logic        [DT_W-1:0]   tick_interval;
    } t_tick;

    // result transaction
    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic        [ANG_W-1:0] heading;
        logic signed [Q15_W-1:0] quat_z;
        logic signed [Q15_W-1:0] quat_w;
        logic                    saturated;
    } t_pose;

    // arctangent of 2^-i as a binary angle, 2^32 per turn
    function automatic logic [31:0] atan_bam(input logic [TBL_IDX_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: design/dd_odo_stream_if.sv
// valid/ready stream channel carrying one payload type
// payload types come from dd_odo_pkg
`default_nettype none

interface dd_odo_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: design/dd_odo_smul.sv
// shift-and-add multiplier, one multiplier bit per cycle
// signed multiplicand, multiplier signed or unsigned; uses no package items
`default_nettype none

module dd_odo_smul #(
    parameter int A_W      = 16,
    parameter int B_W      = 16,
    parameter bit B_SIGNED = 1'b0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [A_W-1:0]   i_a,
    input  logic        [B_W-1:0]   i_b,
    output logic signed [A_W+B_W-1:0] o_p
);

    localparam int P_W = A_W + B_W;
    localparam int CW  = $clog2(B_W + 1);

    logic signed [P_W-1:0] r_a;
    logic        [B_W-1:0] r_b;
    logic signed [P_W-1:0] r_p;
    logic        [CW-1:0]  r_cnt;
    logic signed [P_W-1:0] addend;
    logic                  busy;

    assign busy = (r_cnt < CW'(B_W));

    // partial product for the current multiplier bit, sign bit weighs negative when B_SIGNED is set
    always_comb begin
        if (!r_b[0]) begin
            addend = '0;
        end else if (B_SIGNED && (r_cnt == CW'(B_W - 1))) begin
            addend = -r_a;
        end else begin
            addend = r_a;
        end
    end

    // counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= CW'(B_W);
        end else if (i_start) begin
            r_cnt <= '0;
        end else if (busy) begin
            r_cnt <= r_cnt + CW'(1);
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= P_W'(i_a);
            r_b <= i_b;
            r_p <= '0;
        end else if (busy) begin
            r_a <= r_a <<< 1;
            r_b <= r_b >> 1;
            r_p <= r_p + addend;
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// File: design/dd_odo_cordic.sv
// rotation-mode cordic, one iteration per cycle, Q4.30 internal
// gives Q1.15 cosine and sine of a 32-bit binary angle; uses dd_odo_pkg
`default_nettype none

module dd_odo_cordic #(
    parameter int N_ITER = dd_odo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [dd_odo_pkg::ANG_W-1:0]        i_angle,
    output logic signed [dd_odo_pkg::Q15_W-1:0] o_cos,
    output logic signed [dd_odo_pkg::Q15_W-1:0] o_sin
);

    localparam int DW = dd_odo_pkg::CORDIC_W;
    localparam int CW = $clog2(N_ITER + 1);
    localparam int QW = dd_odo_pkg::Q15_W;

    localparam logic signed [DW-1:0] QUARTER = DW'(64'sd1073741824);
    localparam logic signed [DW-1:0] HALF    = DW'(64'sd2147483648);

    logic signed [DW-1:0] r_x, r_y, r_z;
    logic                 r_neg;
    logic        [CW-1:0] r_cnt;

    logic signed [DW-1:0] z0, z_fold;
    logic                 neg_fold;
    logic signed [DW-1:0] x_sh, y_sh, at;
    logic signed [DW-1:0] x_out, y_out;
    logic                 busy;

    // round Q4.30 to Q1.15 and clip
    function automatic logic signed [QW-1:0] to_q15(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] r;
        r = (v + DW'(16384)) >>> 15;
        if (r > DW'(32767)) begin
            return 16'sh7fff;
        end else if (r < DW'(-32768)) begin
            return 16'sh8000;
        end
        return QW'(r);
    endfunction

    // fold the angle into plus or minus a quarter turn
    always_comb begin
        z0       = DW'(signed'(i_angle));
        z_fold   = z0;
        neg_fold = 1'b0;
        if (z0 > QUARTER) begin
            z_fold   = z0 - HALF;
            neg_fold = 1'b1;
        end else if (z0 < -QUARTER) begin
            z_fold   = z0 + HALF;
            neg_fold = 1'b1;
        end
    end

    // one micro-rotation
    assign busy = (r_cnt < CW'(N_ITER));
    assign x_sh = r_x >>> r_cnt;
    assign y_sh = r_y >>> r_cnt;
    assign at   = DW'(dd_odo_pkg::atan_bam(dd_odo_pkg::TBL_IDX_W'(r_cnt)));

    // iteration counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= CW'(N_ITER);
        end else if (i_start) begin
            r_cnt <= '0;
        end else if (busy) begin
            r_cnt <= r_cnt + CW'(1);
        end
    end

    // rotation registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= DW'(dd_odo_pkg::CORDIC_GAIN_Q30);
            r_y   <= '0;
            r_z   <= z_fold;
            r_neg <= neg_fold;
        end else if (busy) begin
            if (r_z >= 0) begin
                r_x <= r_x - y_sh;
                r_y <= r_y + x_sh;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + y_sh;
                r_y <= r_y - x_sh;
                r_z <= r_z + at;
            end
        end
    end

    // undo the fold and scale
    assign x_out = r_neg ? -r_x : r_x;
    assign y_out = r_neg ? -r_y : r_y;
    assign o_cos = to_q15(x_out);
    assign o_sin = to_q15(y_out);

endmodule

`default_nettype wire

// File: design/differential_drive_odometry_top.sv
// Dead-reckoning odometry for a differential drive. Each accepted tick
// (speed, yaw rate, interval, load flag) moves the pose along the cosine and
// sine of the old heading, then turns the heading, and returns x, y, heading
// and the yaw quaternion z/w of the new heading. A tick runs through the states
// RUN1, FIN1, RUN2 and FIN2: two passes of the shared cordic (one iteration per
// cycle, at most 24) running next to 16-step bit-serial multipliers. A new
// tick is taken only in idle. The next tick is taken while a result still
// waits in the output register. A set load flag first copies the three
// initial registers into the pose. Positions clip at the 32-bit limits and
// raise saturated on that tick.
// depends on dd_odo_pkg, dd_odo_stream_if, dd_odo_smul and dd_odo_cordic
`default_nettype none

module differential_drive_odometry_top #(
    parameter int CORDIC_STEPS = dd_odo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    dd_odo_stream_if.sink                        i_tick,
    dd_odo_stream_if.source                      o_pose,
    input  logic                                 i_cfg_we,
    input  logic [dd_odo_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dd_odo_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int N_ITER = (CORDIC_STEPS < dd_odo_pkg::TBL_LEN) ?
                            CORDIC_STEPS : dd_odo_pkg::TBL_LEN;
    localparam int MUL_LEN = (dd_odo_pkg::DT_W > dd_odo_pkg::Q15_W) ?
                             dd_odo_pkg::DT_W : dd_odo_pkg::Q15_W;
    localparam int PHASE_LEN = (N_ITER > MUL_LEN) ? N_ITER : MUL_LEN;
    localparam int PW = $clog2(PHASE_LEN);

    localparam int POS_W  = dd_odo_pkg::POS_W;
    localparam int ANG_W  = dd_odo_pkg::ANG_W;
    localparam int Q15_W  = dd_odo_pkg::Q15_W;
    localparam int VDT_W  = dd_odo_pkg::VDT_W;
    localparam int PROD_W = dd_odo_pkg::PROD_W;
    localparam int SUM_W  = POS_W + 2;
    localparam int D_W    = PROD_W - 25;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RUN1 = 5'b00010,
        S_FIN1 = 5'b00100,
        S_RUN2 = 5'b01000,
        S_FIN2 = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [PW-1:0] r_cnt;

    logic signed [POS_W-1:0] r_cfg_x, r_cfg_y;
    logic        [ANG_W-1:0] r_cfg_h;
    logic signed [POS_W-1:0] r_x, r_y;
    logic        [ANG_W-1:0] r_h;

    dd_odo_pkg::t_pose r_out;
    logic              r_out_valid;

    logic tick_acc, fin1, fin2_go, phase_end, cordic_start;
    logic [ANG_W-1:0] n_h, cordic_angle;
    logic signed [Q15_W-1:0] w_cos, w_sin;
    logic signed [VDT_W-1:0] w_vdt, w_rdt;
    logic signed [PROD_W-1:0] w_pdx, w_pdy;
    logic [POS_W:0] sx, sy;

    // clipped add of a position step, returns flag and sum
    function automatic logic [POS_W:0] sat_add(input logic signed [POS_W-1:0] base,
                                               input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        logic signed [SUM_W-1:0]  s;
        t = p + PROD_W'(64'sd16777216);
        s = SUM_W'(base) + SUM_W'(signed'(t[PROD_W-1:PROD_W-D_W]));
        if (s > SUM_W'(64'sd2147483647)) begin
            return {1'b1, 32'h7fffffff};
        end else if (s < SUM_W'(-64'sd2147483648)) begin
            return {1'b1, 32'h80000000};
        end
        return {1'b0, s[POS_W-1:0]};
    endfunction

    assign tick_acc  = i_tick.valid && i_tick.ready;
    assign fin1      = (r_state == S_FIN1);
    assign fin2_go   = (r_state == S_FIN2) && (!r_out_valid || o_pose.ready);
    assign phase_end = (r_cnt == PW'(PHASE_LEN - 1));

    assign i_tick.ready   = (r_state == S_IDLE);
    assign o_pose.valid   = r_out_valid;
    assign o_pose.payload = r_out;

    // heading after this tick; rate*dt*16 wraps modulo one turn
    assign n_h = r_h + {w_rdt[ANG_W-5:0], 4'b0000};

    // first pass on the old heading, second on half the new heading
    assign cordic_start = tick_acc || fin1;
    always_comb begin
        if (tick_acc) begin
            cordic_angle = i_tick.payload.load_initial ? r_cfg_h : r_h;
        end else begin
            cordic_angle = {1'b0, n_h[ANG_W-1:1]};
        end
    end

    dd_odo_cordic #(.N_ITER(N_ITER)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_angle (cordic_angle),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    // speed and yaw rate times interval
    dd_odo_smul #(.A_W(dd_odo_pkg::VEL_W), .B_W(dd_odo_pkg::DT_W), .B_SIGNED(1'b0))
    u_mul_vdt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (tick_acc),
        .i_a     (i_tick.payload.linear_velocity),
        .i_b     (i_tick.payload.tick_interval),
        .o_p     (w_vdt)
    );

    dd_odo_smul #(.A_W(dd_odo_pkg::RATE_W), .B_W(dd_odo_pkg::DT_W), .B_SIGNED(1'b0))
    u_mul_rdt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (tick_acc),
        .i_a     (i_tick.payload.angular_rate),
        .i_b     (i_tick.payload.tick_interval),
        .o_p     (w_rdt)
    );

    // distance times cosine and sine of the old heading
    dd_odo_smul #(.A_W(VDT_W), .B_W(Q15_W), .B_SIGNED(1'b1)) u_mul_dx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (fin1),
        .i_a     (w_vdt),
        .i_b     (w_cos),
        .o_p     (w_pdx)
    );

    dd_odo_smul #(.A_W(VDT_W), .B_W(Q15_W), .B_SIGNED(1'b1)) u_mul_dy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (fin1),
        .i_a     (w_vdt),
        .i_b     (w_sin),
        .o_p     (w_pdy)
    );

    assign sx = sat_add(r_x, w_pdx);
    assign sy = sat_add(r_y, w_pdy);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (tick_acc) n_state = S_RUN1;
            S_RUN1: if (phase_end) n_state = S_FIN1;
            S_FIN1: n_state = S_RUN2;
            S_RUN2: if (phase_end) n_state = S_FIN2;
            S_FIN2: if (fin2_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_RUN1) || (r_state == S_RUN2)) begin
                r_cnt <= phase_end ? '0 : r_cnt + PW'(1);
            end else begin
                r_cnt <= '0;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_x <= '0;
            r_cfg_y <= '0;
            r_cfg_h <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dd_odo_pkg::REG_INITIAL_X:       r_cfg_x <= i_cfg_data;
                dd_odo_pkg::REG_INITIAL_Y:       r_cfg_y <= i_cfg_data;
                dd_odo_pkg::REG_INITIAL_HEADING: r_cfg_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pose accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
            r_h <= '0;
        end else if (tick_acc && i_tick.payload.load_initial) begin
            r_x <= r_cfg_x;
            r_y <= r_cfg_y;
            r_h <= r_cfg_h;
        end else if (fin1) begin
            r_h <= n_h;
        end else if (fin2_go) begin
            r_x <= sx[POS_W-1:0];
            r_y <= sy[POS_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin2_go) begin
            r_out_valid <= 1'b1;
        end else if (o_pose.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin2_go) begin
            r_out.pos_x     <= sx[POS_W-1:0];
            r_out.pos_y     <= sy[POS_W-1:0];
            r_out.heading   <= r_h;
            r_out.quat_z    <= w_sin;
            r_out.quat_w    <= w_cos;
            r_out.saturated <= sx[POS_W] || sy[POS_W];
        end
    end

endmodule

`default_nettype wire

// File: design/dd_odo_checker.sv
// port-level checks on the odometry block, bound to the top level
// depends on dd_odo_pkg and differential_drive_odometry_top
`default_nettype none

module dd_odo_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input dd_odo_pkg::t_pose i_out_payload
);

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // a waiting result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // a waiting result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_payload))
        else $error("result changed while stalled");

    // one tick at a time: busy right after a transaction is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("second tick taken while busy");

    // no result can appear straight after a tick is taken
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !$rose(i_out_valid))
        else $error("result appeared too early");

    // a clip flag means one coordinate sits at a limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_payload.saturated |->
            (i_out_payload.pos_x == 32'sh7fffffff) ||
            (i_out_payload.pos_x == 32'sh80000000) ||
            (i_out_payload.pos_y == 32'sh7fffffff) ||
            (i_out_payload.pos_y == 32'sh80000000))
        else $error("saturated without a clipped coordinate");

endmodule

bind differential_drive_odometry_top dd_odo_checker u_dd_odo_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_tick.valid),
    .i_in_ready    (i_tick.ready),
    .i_out_valid   (o_pose.valid),
    .i_out_ready   (o_pose.ready),
    .i_out_payload (o_pose.payload)
);

`default_nettype wire
